FILE: rtl/rmsd_pkg.sv
// Shared types and constants for the range median stuck detector.
package rmsd_pkg;

  localparam int DEF_WINDOW = 5;

  localparam int RANGE_W = 10;
  localparam int TIME_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [RANGE_W-1:0] RANGE_RESET = 10'd400;

  localparam logic [RANGE_W-1:0] STOP_RESET   = 10'd20;
  localparam logic [RANGE_W-1:0] WARN_RESET   = 10'd50;
  localparam logic [RANGE_W-1:0] CLOSE_RESET  = 10'd10;
  localparam logic [RANGE_W-1:0] CHANGE_RESET = 10'd2;
  localparam logic [TIME_W-1:0]  TIMEOUT_RESET = 32'd3000;

  // register word index (byte address / 4)
  typedef enum logic [2:0] {
    REG_STOP    = 3'd0,
    REG_WARN    = 3'd1,
    REG_CLOSE   = 3'd2,
    REG_CHANGE  = 3'd3,
    REG_TIMEOUT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_sample;
    logic [TIME_W-1:0]  now_ms;
  } in_t;

  typedef struct packed {
    logic [RANGE_W-1:0] median_distance;
    logic               obstacle_near;
    logic               obstacle_warn;
    logic               stuck;
  } out_t;

  typedef struct packed {
    logic [RANGE_W-1:0] stop_distance;
    logic [RANGE_W-1:0] warn_distance;
    logic [RANGE_W-1:0] stuck_close_limit;
    logic [RANGE_W-1:0] stuck_change_limit;
    logic [TIME_W-1:0]  stuck_timeout_ms;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic load_in;
    logic scan_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/range_median_stuck_detector.sv
// Top level of the range median filter with obstacle flags and stuck detector.
//
//   port group   direction  handshake            payload
//   in_*         input      in_valid / in_stall   rmsd_pkg::in_t  (range_sample, now_ms)
//   out_*        output     out_valid / out_stall rmsd_pkg::out_t (median, flags, stuck)
//   p*           cfg        psel / penable        5 registers at byte address 4*i
//
// An item passes through ST_IDLE, which writes the sample into the window,
// ST_SCAN for the rank scan, and ST_DONE, which updates the timer.
// The rank scan checks one window entry per cycle against all the others.
// rst_n is synchronous; the window resets to 400 and the config registers to defaults.
// A request is taken while a result waits; the next one stalls until out is free.
module range_median_stuck_detector #(
  parameter int WINDOW = rmsd_pkg::DEF_WINDOW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rmsd_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rmsd_pkg::out_t              out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rmsd_pkg::ADDR_W-1:0] paddr,
  input  logic [rmsd_pkg::DATA_W-1:0] pwdata,
  output logic [rmsd_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  rmsd_pkg::cfg_t cfg;
  rmsd_pkg::cmd_t cmd;
  rmsd_pkg::sts_t sts;

  rmsd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rmsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rmsd_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/rmsd_regs.sv
// Configuration register file behind the APB-style port.
module rmsd_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rmsd_pkg::ADDR_W-1:0] paddr,
  input  logic [rmsd_pkg::DATA_W-1:0] pwdata,
  output logic [rmsd_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output rmsd_pkg::cfg_t              cfg
);

  rmsd_pkg::cfg_t   cfg_r;
  rmsd_pkg::cfg_t   cfg_nxt;
  rmsd_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx    = rmsd_pkg::reg_idx_t'(paddr[rmsd_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        rmsd_pkg::REG_STOP:    cfg_nxt.stop_distance      = pwdata[rmsd_pkg::RANGE_W-1:0];
        rmsd_pkg::REG_WARN:    cfg_nxt.warn_distance      = pwdata[rmsd_pkg::RANGE_W-1:0];
        rmsd_pkg::REG_CLOSE:   cfg_nxt.stuck_close_limit  = pwdata[rmsd_pkg::RANGE_W-1:0];
        rmsd_pkg::REG_CHANGE:  cfg_nxt.stuck_change_limit = pwdata[rmsd_pkg::RANGE_W-1:0];
        rmsd_pkg::REG_TIMEOUT: cfg_nxt.stuck_timeout_ms   = pwdata[rmsd_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      rmsd_pkg::REG_STOP:
        prdata = {{(rmsd_pkg::DATA_W-rmsd_pkg::RANGE_W){1'b0}}, cfg_r.stop_distance};
      rmsd_pkg::REG_WARN:
        prdata = {{(rmsd_pkg::DATA_W-rmsd_pkg::RANGE_W){1'b0}}, cfg_r.warn_distance};
      rmsd_pkg::REG_CLOSE:
        prdata = {{(rmsd_pkg::DATA_W-rmsd_pkg::RANGE_W){1'b0}}, cfg_r.stuck_close_limit};
      rmsd_pkg::REG_CHANGE:
        prdata = {{(rmsd_pkg::DATA_W-rmsd_pkg::RANGE_W){1'b0}}, cfg_r.stuck_change_limit};
      rmsd_pkg::REG_TIMEOUT:
        prdata = cfg_r.stuck_timeout_ms;
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_distance      <= rmsd_pkg::STOP_RESET;
      cfg_r.warn_distance      <= rmsd_pkg::WARN_RESET;
      cfg_r.stuck_close_limit  <= rmsd_pkg::CLOSE_RESET;
      cfg_r.stuck_change_limit <= rmsd_pkg::CHANGE_RESET;
      cfg_r.stuck_timeout_ms   <= rmsd_pkg::TIMEOUT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/rmsd_ctrl.sv
// Sequencer: accept, rank scan over the window, result hand-off.
module rmsd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rmsd_pkg::sts_t sts,
  output rmsd_pkg::cmd_t cmd
);

  rmsd_pkg::state_t state_r;
  rmsd_pkg::state_t state_nxt;

  assign in_stall = (state_r != rmsd_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      rmsd_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = rmsd_pkg::ST_SCAN;
        end
      end
      rmsd_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = rmsd_pkg::ST_DONE;
        end
      end
      rmsd_pkg::ST_DONE: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = rmsd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rmsd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmsd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/rmsd_dp.sv
// Datapath: sample window, rank-count median search, flags and stuck timer.
module rmsd_dp #(
  parameter int WINDOW = rmsd_pkg::DEF_WINDOW
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rmsd_pkg::in_t  in_data,
  input  rmsd_pkg::cfg_t cfg,
  input  rmsd_pkg::cmd_t cmd,
  output rmsd_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_stall,
  output rmsd_pkg::out_t out_data
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] MID_RANK = CNT_W'(WINDOW / 2);

  logic [rmsd_pkg::RANGE_W-1:0] win_r [WINDOW];
  logic [IDX_W-1:0]             slot_r;
  logic [IDX_W-1:0]             cand_r;
  logic [rmsd_pkg::TIME_W-1:0]  now_r;
  logic [rmsd_pkg::RANGE_W-1:0] med_r;
  logic [rmsd_pkg::RANGE_W-1:0] prev_r;
  logic [rmsd_pkg::TIME_W-1:0]  since_r;
  logic                         timing_r;
  logic                         out_valid_r;
  rmsd_pkg::out_t               out_r;

  logic [rmsd_pkg::RANGE_W-1:0] cand_val;
  logic [CNT_W-1:0]             rank;
  logic [rmsd_pkg::RANGE_W-1:0] diff;
  logic                         stable;
  logic                         timing_nxt;
  logic [rmsd_pkg::TIME_W-1:0]  since_nxt;
  logic [rmsd_pkg::TIME_W-1:0]  elapsed;
  rmsd_pkg::out_t               out_nxt;

  // stable rank: smaller entries, plus equal entries at lower slots
  assign cand_val = win_r[cand_r];
  always_comb begin
    rank = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if ((win_r[j] < cand_val) ||
          ((win_r[j] == cand_val) && (IDX_W'(j) < cand_r))) begin
        rank = rank + CNT_W'(1);
      end
    end
  end

  assign sts.scan_last = (cand_r == LAST_IDX);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign diff   = (med_r >= prev_r) ? (med_r - prev_r) : (prev_r - med_r);
  assign stable = (med_r < cfg.stuck_close_limit) && (diff < cfg.stuck_change_limit);

  always_comb begin
    timing_nxt = timing_r;
    since_nxt  = since_r;
    if (stable) begin
      if (!timing_r) begin
        timing_nxt = 1'b1;
        since_nxt  = now_r;
      end
    end else begin
      timing_nxt = 1'b0;
      since_nxt  = '0;
    end
  end

  assign elapsed = now_r - since_nxt;

  always_comb begin
    out_nxt.median_distance = med_r;
    out_nxt.obstacle_near   = (med_r < cfg.stop_distance);
    out_nxt.obstacle_warn   = (med_r < cfg.warn_distance);
    out_nxt.stuck           = timing_nxt && (elapsed > cfg.stuck_timeout_ms);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= rmsd_pkg::RANGE_RESET;
      end
      slot_r      <= '0;
      prev_r      <= '0;
      since_r     <= '0;
      timing_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        win_r[slot_r] <= in_data.range_sample;
        slot_r        <= (slot_r == LAST_IDX) ? '0 : slot_r + IDX_W'(1);
      end
      if (cmd.finish) begin
        prev_r   <= med_r;
        since_r  <= since_nxt;
        timing_r <= timing_nxt;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_r  <= in_data.now_ms;
      cand_r <= '0;
    end else if (cmd.scan_step && !sts.scan_last) begin
      cand_r <= cand_r + IDX_W'(1);
    end
    if (cmd.scan_step && (rank == MID_RANK)) begin
      med_r <= cand_val;
    end
    if (cmd.finish) begin
      out_r <= out_nxt;
    end
  end

endmodule
